// ===== design/dfa_tt_pkg.sv =====
// Shared types and constants for the automaton transition table.
package dfa_tt_pkg;

    localparam int DFA_NUM_STATES  = 256;
    localparam int DFA_NUM_SYMBOLS = 256;

    localparam int STATE_W  = 8;
    localparam int SYMBOL_W = 8;

    typedef enum logic [1:0] {
        MODE_INS_STATE = 2'd0,
        MODE_INS_TRANS = 2'd1,
        MODE_REM_TRANS = 2'd2,
        MODE_MOVE      = 2'd3
    } dfa_tt_mode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_NOT_ALLOC = 2'd2,
        ST_NO_MATCH  = 2'd3
    } dfa_tt_status_t;

    typedef struct packed {
        logic accepting;
        logic allocated;
    } dfa_tt_row_t;

    typedef struct packed {
        logic                 valid;
        logic [STATE_W-1:0]   target;
    } dfa_tt_entry_t;

    // Write-back request from the operation stage to the table store.
    typedef struct packed {
        logic          row_we;
        dfa_tt_row_t   row;
        logic          ent_we;
        dfa_tt_entry_t ent;
    } dfa_tt_wr_t;

endpackage

// ===== design/dfa_tt_if.sv =====
// Valid/ready channel interfaces for request and response beats.
interface dfa_tt_req_if;
    import dfa_tt_pkg::*;

    logic                valid;
    logic                ready;
    logic [1:0]          mode;
    logic [STATE_W-1:0]  state_index;
    logic [SYMBOL_W-1:0] symbol;
    logic [STATE_W-1:0]  target_state;
    logic                accepting_flag;

    modport source (output valid, mode, state_index, symbol, target_state, accepting_flag,
                    input ready);
    modport sink   (input valid, mode, state_index, symbol, target_state, accepting_flag,
                    output ready);
endinterface

interface dfa_tt_rsp_if;
    import dfa_tt_pkg::*;

    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [STATE_W-1:0] next_state;
    logic               next_valid;

    modport source (output valid, status, next_state, next_valid, input ready);
    modport sink   (input valid, status, next_state, next_valid, output ready);
endinterface

// ===== design/dfa_transition_table_core.sv =====
// Top level of the automaton transition table: operation stage and response register.
// A taken beat enters the operation stage; the response register loads as it advances.
// Throughput: one request beat per cycle while rsp.ready holds; the table memories take
// one read and one write per cycle, and a read that meets the write-back of the previous
// beat is forwarded. Reset: all rows and entries are cleared by a sweep after rst_n
// rises; no request is taken during the sweep.
module dfa_transition_table_core #(
    parameter int NUM_STATES  = dfa_tt_pkg::DFA_NUM_STATES,
    parameter int NUM_SYMBOLS = dfa_tt_pkg::DFA_NUM_SYMBOLS
) (
    input  logic          clk,
    input  logic          rst_n,
    dfa_tt_req_if.sink    req,
    dfa_tt_rsp_if.source  rsp
);
    import dfa_tt_pkg::*;

    localparam int ROW_W = $clog2(NUM_STATES);
    localparam int SYM_W = $clog2(NUM_SYMBOLS);

    // Operation stage: the beat whose table reads are in flight.
    logic                s2_vld_reg, s2_vld_next;
    dfa_tt_mode_t        s2_mode_reg;
    logic [STATE_W-1:0]  s2_row_reg;
    logic [SYMBOL_W-1:0] s2_sym_reg;
    logic [STATE_W-1:0]  s2_target_reg;
    logic                s2_acc_reg;

    // Response register, which separates the two channels.
    logic                out_vld_reg, out_vld_next;
    dfa_tt_status_t      out_status_reg;
    logic [STATE_W-1:0]  out_next_reg;
    logic                out_nv_reg;

    logic                accept;
    logic                s2_adv;
    logic                store_busy;
    logic [31:0]         row_wide;
    logic [31:0]         sym_wide;
    logic                row_ok, sym_ok;

    dfa_tt_wr_t          wr;
    dfa_tt_row_t         row_data;
    dfa_tt_entry_t       ent_data;

    dfa_tt_status_t      res_status;
    logic [STATE_W-1:0]  res_next;
    logic                res_nv;

    // The stage advances when the response register is empty or being drained.
    assign s2_adv    = s2_vld_reg && (!out_vld_reg || rsp.ready);
    assign req.ready = !store_busy && (!s2_vld_reg || s2_adv);
    assign accept    = req.valid && req.ready;

    assign row_wide = 32'(req.state_index);
    assign sym_wide = 32'(req.symbol);

    dfa_tt_store #(
        .NUM_STATES  (NUM_STATES),
        .NUM_SYMBOLS (NUM_SYMBOLS),
        .ROW_W       (ROW_W),
        .SYM_W       (SYM_W)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_row   (row_wide[ROW_W-1:0]),
        .rd_sym   (sym_wide[SYM_W-1:0]),
        .wr       (wr),
        .row_data (row_data),
        .ent_data (ent_data),
        .busy     (store_busy)
    );

    assign row_ok = 32'(s2_row_reg) < 32'(NUM_STATES);
    assign sym_ok = 32'(s2_sym_reg) < 32'(NUM_SYMBOLS);

    // Decode of the operation. Writes are only issued for in-range indices,
    // so an out-of-range beat never touches an aliased row or entry.
    always_comb
    begin
        res_status = ST_OK;
        res_next   = '0;
        res_nv     = 1'b0;
        wr         = '0;
        if (!row_ok)
        begin
            res_status = ST_INVALID;
        end
        else if (s2_mode_reg == MODE_INS_STATE)
        begin
            wr.row_we        = 1'b1;
            wr.row.allocated = 1'b1;
            wr.row.accepting = s2_acc_reg;
        end
        else if (!sym_ok)
        begin
            res_status = ST_INVALID;
        end
        else
        begin
            case (s2_mode_reg)
                MODE_INS_TRANS:
                begin
                    wr.row_we        = 1'b1;
                    wr.row.allocated = 1'b1;
                    wr.row.accepting = row_data.accepting;
                    wr.ent_we        = 1'b1;
                    wr.ent.valid     = 1'b1;
                    wr.ent.target    = s2_target_reg;
                end
                MODE_REM_TRANS:
                begin
                    if (!row_data.allocated)
                    begin
                        res_status = ST_NOT_ALLOC;
                    end
                    else if (!ent_data.valid)
                    begin
                        res_status = ST_NO_MATCH;
                    end
                    else
                    begin
                        wr.ent_we = 1'b1;
                    end
                end
                MODE_MOVE:
                begin
                    if (row_data.allocated && ent_data.valid)
                    begin
                        res_next = ent_data.target;
                        res_nv   = 1'b1;
                    end
                end
                default:
                begin
                    res_status = ST_OK;
                end
            endcase
        end
        // Write back exactly once, in the cycle the beat leaves the stage.
        wr.row_we = wr.row_we && s2_adv;
        wr.ent_we = wr.ent_we && s2_adv;
    end

    always_comb
    begin
        s2_vld_next = s2_vld_reg;
        if (accept)
        begin
            s2_vld_next = 1'b1;
        end
        else if (s2_adv)
        begin
            s2_vld_next = 1'b0;
        end

        out_vld_next = out_vld_reg;
        if (s2_adv)
        begin
            out_vld_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            s2_vld_reg  <= s2_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s2_mode_reg   <= dfa_tt_mode_t'(req.mode);
            s2_row_reg    <= req.state_index;
            s2_sym_reg    <= req.symbol;
            s2_target_reg <= req.target_state;
            s2_acc_reg    <= req.accepting_flag;
        end
        if (s2_adv)
        begin
            out_status_reg <= res_status;
            out_next_reg   <= res_next;
            out_nv_reg     <= res_nv;
        end
    end

    assign rsp.valid      = out_vld_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.next_state = out_next_reg;
    assign rsp.next_valid = out_nv_reg;

    // No request is taken while the clearing sweep runs.
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        store_busy |-> !req.ready)
        else $error("request taken during clearing sweep");

    // Every accepted beat occupies the operation stage in the next cycle.
    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s2_vld_reg)
        else $error("accepted beat lost before operation stage");

    // Table writes come only from a beat leaving the operation stage.
    a_write_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (wr.row_we || wr.ent_we) |-> s2_adv)
        else $error("table write without advancing beat");

    // A found target always carries ok status.
    a_found_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_nv_reg) |-> (out_status_reg == ST_OK))
        else $error("next_valid set with non-ok status");

    // Without a found target the returned state is zero.
    a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !out_nv_reg) |-> (out_next_reg == '0))
        else $error("next_state nonzero without a target");

endmodule

// ===== design/dfa_tt_store.sv =====
// Row and transition memories with clearing sweep and write-back forwarding.
module dfa_tt_store #(
    parameter int NUM_STATES  = dfa_tt_pkg::DFA_NUM_STATES,
    parameter int NUM_SYMBOLS = dfa_tt_pkg::DFA_NUM_SYMBOLS,
    parameter int ROW_W       = $clog2(NUM_STATES),
    parameter int SYM_W       = $clog2(NUM_SYMBOLS)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     rd_en,
    input  logic [ROW_W-1:0]         rd_row,
    input  logic [SYM_W-1:0]         rd_sym,
    input  dfa_tt_pkg::dfa_tt_wr_t   wr,
    output dfa_tt_pkg::dfa_tt_row_t   row_data,
    output dfa_tt_pkg::dfa_tt_entry_t ent_data,
    output logic                     busy
);
    import dfa_tt_pkg::*;

    localparam int ADDR_W    = ROW_W + SYM_W;
    localparam int ENT_DEPTH = 2 ** ADDR_W;
    localparam int ROW_DEPTH = 2 ** ROW_W;

    dfa_tt_entry_t ent_mem [ENT_DEPTH];
    dfa_tt_row_t   row_mem [ROW_DEPTH];

    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic              clearing_reg, clearing_next;

    logic [ROW_W-1:0]  row_addr_reg;
    logic [ADDR_W-1:0] ent_addr_reg;
    dfa_tt_row_t       row_rd_reg;
    dfa_tt_entry_t     ent_rd_reg;

    logic              fwd_row_vld_reg, fwd_ent_vld_reg;
    logic [ROW_W-1:0]  fwd_row_addr_reg;
    logic [ADDR_W-1:0] fwd_ent_addr_reg;
    dfa_tt_row_t       fwd_row_data_reg;
    dfa_tt_entry_t     fwd_ent_data_reg;

    logic              row_we, ent_we;
    logic [ROW_W-1:0]  row_waddr;
    logic [ADDR_W-1:0] ent_waddr;
    dfa_tt_row_t       row_wdata;
    dfa_tt_entry_t     ent_wdata;

    always_comb
    begin
        clr_cnt_next  = clr_cnt_reg;
        clearing_next = clearing_reg;
        if (clearing_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == {ADDR_W{1'b1}})
            begin
                clearing_next = 1'b0;
            end
        end
    end

    // During the sweep every address is zeroed; afterwards writes go to the
    // address of the item currently in the operation stage.
    always_comb
    begin
        if (clearing_reg)
        begin
            row_we    = 1'b1;
            ent_we    = 1'b1;
            row_waddr = clr_cnt_reg[ROW_W-1:0];
            ent_waddr = clr_cnt_reg;
            row_wdata = '0;
            ent_wdata = '0;
        end
        else
        begin
            row_we    = wr.row_we;
            ent_we    = wr.ent_we;
            row_waddr = row_addr_reg;
            ent_waddr = ent_addr_reg;
            row_wdata = wr.row;
            ent_wdata = wr.ent;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg     <= '0;
            clearing_reg    <= 1'b1;
            fwd_row_vld_reg <= 1'b0;
            fwd_ent_vld_reg <= 1'b0;
        end
        else
        begin
            clr_cnt_reg  <= clr_cnt_next;
            clearing_reg <= clearing_next;
            if (row_we)
            begin
                fwd_row_vld_reg <= 1'b1;
            end
            if (ent_we)
            begin
                fwd_ent_vld_reg <= 1'b1;
            end
        end
    end

    // The most recent write of each memory is kept to cover a read issued in
    // the same cycle as that write.
    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            fwd_row_addr_reg <= row_waddr;
            fwd_row_data_reg <= row_wdata;
        end
        if (ent_we)
        begin
            fwd_ent_addr_reg <= ent_waddr;
            fwd_ent_data_reg <= ent_wdata;
        end
        if (rd_en)
        begin
            row_addr_reg <= rd_row;
            ent_addr_reg <= {rd_row, rd_sym};
        end
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_mem[row_waddr] <= row_wdata;
        end
        if (rd_en)
        begin
            row_rd_reg <= row_mem[rd_row];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_mem[ent_waddr] <= ent_wdata;
        end
        if (rd_en)
        begin
            ent_rd_reg <= ent_mem[{rd_row, rd_sym}];
        end
    end

    assign row_data = (fwd_row_vld_reg && fwd_row_addr_reg == row_addr_reg)
                      ? fwd_row_data_reg : row_rd_reg;
    assign ent_data = (fwd_ent_vld_reg && fwd_ent_addr_reg == ent_addr_reg)
                      ? fwd_ent_data_reg : ent_rd_reg;
    assign busy     = clearing_reg;

endmodule
